[hw/rtl/cia_pkg.sv]
// Package for the checked integer ALU: operation and status codes,
// default data width and the control word carried down the pipeline.
// No dependencies.
package cia_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_REM = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_UNF  = 2'd2,
        ST_DIVZ = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       neg_prod;
        logic       neg_quot;
        logic       neg_rem;
        status_t    early_st;
    } ctl_t;

endpackage

[hw/rtl/cia_stage.sv]
// One iteration stage of the checked integer ALU pipeline: one bit of the
// shift-add multiply and one bit of the restoring divide. Uses cia_pkg.
module cia_stage #(
    parameter int W   = 32,
    parameter int IDX = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cia_pkg::ctl_t   in_ctl,
    input  logic [W-1:0]    in_ua,
    input  logic [W-1:0]    in_ub,
    input  logic [2*W-1:0]  in_acc,
    input  logic [W-1:0]    in_rem,
    input  logic [W-1:0]    in_quot,
    input  logic [W-1:0]    in_val,
    output logic            out_valid,
    output cia_pkg::ctl_t   out_ctl,
    output logic [W-1:0]    out_ua,
    output logic [W-1:0]    out_ub,
    output logic [2*W-1:0]  out_acc,
    output logic [W-1:0]    out_rem,
    output logic [W-1:0]    out_quot,
    output logic [W-1:0]    out_val
);
    import cia_pkg::*;

    logic [W:0]     trial;
    logic [W:0]     diff;
    logic           take;
    logic [2*W-1:0] addend;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   quot_next;
    logic [2*W-1:0] acc_next;

    always_comb begin
        // bring down the next dividend bit, MSB first
        trial     = {in_rem, in_ua[W-1-IDX]};
        diff      = trial - {1'b0, in_ub};
        take      = !diff[W];
        rem_next  = take ? diff[W-1:0] : trial[W-1:0];
        quot_next = {in_quot[W-2:0], take};
        addend    = in_ub[IDX] ? ({{W{1'b0}}, in_ua} << IDX) : '0;
        acc_next  = in_acc + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctl  <= in_ctl;
            out_ua   <= in_ua;
            out_ub   <= in_ub;
            out_acc  <= acc_next;
            out_rem  <= rem_next;
            out_quot <= quot_next;
            out_val  <= in_val;
        end
    end

endmodule

[hw/rtl/checked_integer_alu_top.sv]
// Checked signed integer ALU: an accepted input word passes through the input
// register, one stage per operand bit for the shift-add multiplier and
// restoring divider, and the output register before its result word shows
// valid. Throughput one word per cycle; the whole pipeline advances on one
// enable and holds while the output word waits. Synchronous active-low reset
// clears the valid bits only.
// Depends on cia_pkg and cia_stage.
module checked_integer_alu_top #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_kind,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_value,
    output logic [1:0]                   m_status
);
    import cia_pkg::*;

    localparam int W = DATA_WIDTH;

    // advance every stage together whenever the output can take a word
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // input stage: decode, add/sub with checks, magnitudes, early errors
    logic [W:0]   sum;
    logic [W:0]   dif;
    logic         a_neg;
    logic         b_neg;
    logic         b_zero;
    logic         a_min;
    logic         b_m1;
    ctl_t         ctl_in;
    logic [W-1:0] val_in;
    logic [W-1:0] ua_in;
    logic [W-1:0] ub_in;

    always_comb begin
        a_neg  = s_operand_a[W-1];
        b_neg  = s_operand_b[W-1];
        b_zero = (s_operand_b == '0);
        a_min  = (s_operand_a == {1'b1, {(W-1){1'b0}}});
        b_m1   = (s_operand_b == {W{1'b1}});
        sum    = {a_neg, s_operand_a} + {b_neg, s_operand_b};
        dif    = {a_neg, s_operand_a} - {b_neg, s_operand_b};
        ua_in  = a_neg ? (~s_operand_a + 1'b1) : s_operand_a;
        ub_in  = b_neg ? (~s_operand_b + 1'b1) : s_operand_b;

        ctl_in.kind     = s_kind;
        ctl_in.neg_prod = a_neg ^ b_neg;
        ctl_in.neg_quot = a_neg ^ b_neg;
        ctl_in.neg_rem  = a_neg;
        ctl_in.early_st = ST_OK;
        val_in          = '0;
        unique case (s_kind)
            KIND_ADD: begin
                if (!sum[W] && sum[W-1])      ctl_in.early_st = ST_OVF;
                else if (sum[W] && !sum[W-1]) ctl_in.early_st = ST_UNF;
                else                          val_in = sum[W-1:0];
            end
            KIND_SUB: begin
                if (!dif[W] && dif[W-1])      ctl_in.early_st = ST_OVF;
                else if (dif[W] && !dif[W-1]) ctl_in.early_st = ST_UNF;
                else                          val_in = dif[W-1:0];
            end
            KIND_DIV: begin
                if (b_zero)             ctl_in.early_st = ST_DIVZ;
                else if (a_min && b_m1) ctl_in.early_st = ST_OVF;
            end
            KIND_REM: begin
                if (b_zero) ctl_in.early_st = ST_DIVZ;
            end
            default: ;
        endcase
    end

    // stage arrays: index 0 is the input register, W the last iteration
    logic           v_reg    [0:W];
    ctl_t           ctl_reg  [0:W];
    logic [W-1:0]   ua_reg   [0:W];
    logic [W-1:0]   ub_reg   [0:W];
    logic [2*W-1:0] acc_reg  [0:W];
    logic [W-1:0]   rem_reg  [0:W];
    logic [W-1:0]   quot_reg [0:W];
    logic [W-1:0]   val_reg  [0:W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0]  <= ctl_in;
            ua_reg[0]   <= ua_in;
            ub_reg[0]   <= ub_in;
            acc_reg[0]  <= '0;
            rem_reg[0]  <= '0;
            quot_reg[0] <= '0;
            val_reg[0]  <= val_in;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_stage
        cia_stage #(.W(W), .IDX(k)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (v_reg[k]),
            .in_ctl    (ctl_reg[k]),
            .in_ua     (ua_reg[k]),
            .in_ub     (ub_reg[k]),
            .in_acc    (acc_reg[k]),
            .in_rem    (rem_reg[k]),
            .in_quot   (quot_reg[k]),
            .in_val    (val_reg[k]),
            .out_valid (v_reg[k+1]),
            .out_ctl   (ctl_reg[k+1]),
            .out_ua    (ua_reg[k+1]),
            .out_ub    (ub_reg[k+1]),
            .out_acc   (acc_reg[k+1]),
            .out_rem   (rem_reg[k+1]),
            .out_quot  (quot_reg[k+1]),
            .out_val   (val_reg[k+1])
        );
    end

    // final select: range check the product, apply signs, zero on error
    ctl_t           fc;
    logic [2*W-1:0] lim;
    logic [W-1:0]   prod_lo;
    logic [W-1:0]   value_next;
    status_t        status_next;

    always_comb begin
        fc          = ctl_reg[W];
        prod_lo     = acc_reg[W][W-1:0];
        lim         = {{(W+1){1'b0}}, {(W-1){1'b1}}} + {{(2*W-1){1'b0}}, fc.neg_prod};
        value_next  = '0;
        status_next = fc.early_st;
        unique case (fc.kind)
            KIND_ADD, KIND_SUB: value_next = val_reg[W];
            KIND_MUL: begin
                if (acc_reg[W] > lim) status_next = fc.neg_prod ? ST_UNF : ST_OVF;
                else value_next = fc.neg_prod ? (~prod_lo + 1'b1) : prod_lo;
            end
            KIND_DIV: begin
                if (fc.early_st == ST_OK)
                    value_next = fc.neg_quot ? (~quot_reg[W] + 1'b1) : quot_reg[W];
            end
            KIND_REM: begin
                if (fc.early_st == ST_OK)
                    value_next = fc.neg_rem ? (~rem_reg[W] + 1'b1) : rem_reg[W];
            end
            default: ;
        endcase
        if (status_next != ST_OK) value_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= v_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_value  <= value_next;
            m_status <= status_next;
        end
    end

    // an error word always carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_value == '0))
        else $error("error result with nonzero value");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // a stall holds the last iteration stage in place
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(v_reg[W]) && $stable(quot_reg[W]))
        else $error("pipeline moved during stall");

    // a divide by zero is only reported for divide or remainder
    a_divz_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[W] && (status_next == ST_DIVZ) |->
            (fc.kind == KIND_DIV) || (fc.kind == KIND_REM))
        else $error("divide by zero on a non-divide word");

endmodule

[sim/testbench.sv]
// Testbench for checked_integer_alu_top: drives operation words, predicts each
// result word in SystemVerilog, and checks results in order.
// Depends on cia_pkg and the checked_integer_alu_top RTL.
`timescale 1ns / 1ps

module testbench;
    import cia_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = W + 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic [1:0]          status;
    } alu_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [2:0]          s_kind = '0;
    logic signed [W-1:0] s_operand_a = '0;
    logic signed [W-1:0] s_operand_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [W-1:0] m_value;
    logic [1:0]          m_status;

    alu_result_t expected_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          stall_enable = 1'b1;

    checked_integer_alu_top #(.DATA_WIDTH(W)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_status(m_status)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Compute the checked result with wide arithmetic; the exact value of any
    // 32-bit add, subtract or multiply fits in 66 signed bits.
    function automatic alu_result_t alu_compute(logic [2:0] kind,
                                                logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic signed [65:0] exact;
        logic signed [65:0] vmax;
        logic signed [65:0] vmin;
        alu_result_t res;
        wa = a;
        wb = b;
        vmax = (66'sd1 <<< (W - 1)) - 1;
        vmin = -(66'sd1 <<< (W - 1));
        res.value = '0;
        res.status = ST_OK;
        exact = 0;
        case (kind)
            KIND_ADD, KIND_SUB, KIND_MUL: begin
                if (kind == KIND_ADD) exact = wa + wb;
                else if (kind == KIND_SUB) exact = wa - wb;
                else exact = wa * wb;
                if (exact > vmax) res.status = ST_OVF;
                else if (exact < vmin) res.status = ST_UNF;
                else res.value = exact[W-1:0];
            end
            KIND_DIV: begin
                if (wb == 0) res.status = ST_DIVZ;
                else if (wa == vmin && wb == -1) res.status = ST_OVF;
                else begin
                    exact = wa / wb;
                    res.value = exact[W-1:0];
                end
            end
            KIND_REM: begin
                if (wb == 0) res.status = ST_DIVZ;
                else begin
                    exact = wa % wb;
                    res.value = exact[W-1:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Send one word: predict at acceptance, and drop valid only when no word follows.
    task automatic send_word(logic [2:0] kind, logic [W-1:0] a, logic [W-1:0] b,
                             bit more);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(alu_compute(kind, a, b));
        if (!more) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 70000) - 35000;
            4: return 32'h0001_0000 + $urandom_range(0, 40000) - 20000;
            5: return -(32'h0000_b505 + $urandom_range(0, 4));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Directed: field extremes, each operation, and every special case.
    task automatic test_directed();
        logic [W-1:0] mn = 32'h8000_0000;
        logic [W-1:0] mx = 32'h7fff_ffff;
        logic [W-1:0] m1 = 32'hffff_ffff;
        send_word(KIND_ADD, mx, 1, 1);
        send_word(KIND_ADD, mn, m1, 1);
        send_word(KIND_ADD, mx, mn, 1);
        send_word(KIND_SUB, mx, m1, 1);
        send_word(KIND_SUB, mn, 1, 1);
        send_word(KIND_SUB, 0, mn, 1);
        send_word(KIND_MUL, mn, m1, 1);
        send_word(KIND_MUL, mn, 1, 1);
        send_word(KIND_MUL, 32'h0001_0000, 32'hffff_8000, 1);
        send_word(KIND_MUL, 32'h0001_0000, 32'h0000_8000, 1);
        send_word(KIND_MUL, mx, mx, 1);
        send_word(KIND_MUL, mx, mn, 1);
        send_word(KIND_DIV, mn, m1, 1);
        send_word(KIND_DIV, 7, 0, 1);
        send_word(KIND_DIV, 32'hffff_fff9, 2, 1);
        send_word(KIND_REM, mn, m1, 1);
        send_word(KIND_REM, 32'hffff_fff9, 2, 1);
        send_word(KIND_REM, 5, 0, 1);
        send_word(3'd5, mx, mx, 1);
        send_word(3'd6, mn, 1, 1);
        send_word(3'd7, m1, m1, 0);
    endtask

    // Random bursts with random gaps.
    task automatic test_random(int count);
        int sent = 0;
        int burst;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_word(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4)),
                          pick_operand(), pick_operand(),
                          (i < burst - 1) && (sent < count - 1));
                sent++;
            end
            repeat ($urandom_range(0, 4)) @(posedge aclk);
        end
    endtask

    // Pause the sender until the pipeline has drained, then go on.
    task automatic test_drain_pause();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    // Full throughput with the receiver always ready.
    task automatic test_no_stall();
        stall_enable = 1'b0;
        for (int i = 0; i < 120; i++)
            send_word(3'($urandom_range(0, 4)), pick_operand(), pick_operand(), i < 119);
        stall_enable = 1'b1;
    endtask

    // Receiver stall pattern: random runs of ready and not-ready.
    always @(posedge aclk) begin
        if (!stall_enable) m_ready <= 1'b1;
        else if ($urandom_range(0, 5) == 0) m_ready <= ~m_ready;
    end

    // Check each accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        alu_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word value=%0d status=%0d",
                         $time, m_value, m_status);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_value !== exp_res.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, exp_res.value, m_value);
                    error_count++;
                end
                if (m_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("checked_integer_alu_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(300);
        test_drain_pause();
        test_no_stall();
        test_random(250);
        wait_drained();
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("checked_integer_alu_top: match");
        else
            $display("checked_integer_alu_top: mismatch");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/cia_pkg.sv
hw/rtl/cia_stage.sv
hw/rtl/checked_integer_alu_top.sv
sim/testbench.sv
